@@ sv/lphm_pkg.sv @@
// Package for the linear probing hash map: codes, state types, table entry.
// No dependencies; used by lphm_channels, lphm_hash and the top level.
`default_nettype none

package lphm_pkg;

   localparam int DEPTH_DEFAULT = 1024;
   localparam int KEY_W         = 64;
   localparam int VALUE_W       = 32;
   localparam int COUNT_W       = 11;
   localparam logic [31:0] KNUTH_MUL = 32'd2654435761;

   localparam logic [1:0] ACT_INSERT = 2'd0;
   localparam logic [1:0] ACT_DELETE = 2'd1;
   localparam logic [1:0] ACT_SEARCH = 2'd2;
   localparam logic [1:0] ACT_CLEAR  = 2'd3;

   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_EXISTS  = 2'd1;
   localparam logic [1:0] STAT_FULL    = 2'd2;
   localparam logic [1:0] STAT_MISSING = 2'd3;

   typedef struct packed {
      logic               used;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
   } entry_type;

   typedef enum logic [2:0] {
      ST_SWEEP, ST_IDLE, ST_HASH, ST_READ, ST_CHECK, ST_DONE
   } ctrl_state_type;

   typedef enum logic [1:0] {
      PH_LOOKUP, PH_SHIFT, PH_REINS
   } phase_type;

   typedef enum logic [1:0] {
      H_IDLE, H_ADD, H_MOD, H_DONE
   } hash_state_type;

   // integer mode compares the low 32 bits only
   function automatic logic keys_match(input logic kind, input logic [KEY_W-1:0] a,
                                       input logic [KEY_W-1:0] b);
      keys_match = kind ? (a == b) : (a[31:0] == b[31:0]);
   endfunction

endpackage

`default_nettype wire

@@ sv/lphm_channels.sv @@
// Request and response channel interfaces of the hash map.
// Depends on lphm_pkg for field widths.
`default_nettype none

interface lphm_req_if;
   logic                        valid;
   logic                        ready;
   logic [1:0]                  action;
   logic [lphm_pkg::KEY_W-1:0]  key;
   logic [lphm_pkg::VALUE_W-1:0] value;
   modport source (output valid, action, key, value, input ready);
   modport sink   (input valid, action, key, value, output ready);
endinterface

interface lphm_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    status;
   logic                          found;
   logic [lphm_pkg::VALUE_W-1:0]  found_value;
   logic [lphm_pkg::COUNT_W-1:0]  entry_count;
   modport source (output valid, status, found, found_value, entry_count, input ready);
   modport sink   (input valid, status, found, found_value, entry_count, output ready);
endinterface

`default_nettype wire

@@ sv/lphm_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module lphm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

@@ sv/lphm_hash.sv @@
// Home slot unit: multiplicative hash, then reduction modulo the table depth.
// Depends on lphm_pkg. Power-of-two depths skip the 4-bit-per-cycle remainder loop.
`default_nettype none

module lphm_hash #(
   parameter int TABLE_DEPTH = lphm_pkg::DEPTH_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic [lphm_pkg::KEY_W-1:0]        key,
   input  wire logic                              key_kind,
   output      logic                              done,
   output      logic [lphm_pkg::KEY_W-1:0]        home,
   output      logic [$clog2(TABLE_DEPTH)-1:0]    slot
);

   localparam int  SW   = $clog2(TABLE_DEPTH);
   localparam int  RW   = SW + 1;
   localparam bit  POW2 = (TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0;
   localparam logic [RW:0] DIVISOR = (RW + 1)'(TABLE_DEPTH);

   lphm_pkg::hash_state_type state_ff, state_in;
   logic        kind_ff, kind_in;
   logic [63:0] plo_ff, plo_in;
   logic [31:0] phi_ff, phi_in;
   logic [63:0] home_ff, home_in;
   logic [63:0] sh_ff, sh_in;
   logic [RW-1:0] rem_ff, rem_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [63:0] plo_c;
   logic [31:0] phi_c;
   logic [63:0] sum_c;
   logic [RW-1:0] rem_step;
   logic [RW:0] t;

   assign plo_c = 64'(key[31:0]) * 64'(lphm_pkg::KNUTH_MUL);
   assign phi_c = key[63:32] * lphm_pkg::KNUTH_MUL;
   assign sum_c = kind_ff ? (plo_ff + {phi_ff, 32'd0}) : {32'd0, plo_ff[31:0]};

   // four restoring remainder steps, one input bit each
   always_comb begin
      rem_step = rem_ff;
      t        = '0;
      for (int b = 0; b < 4; b++) begin
         t = {rem_step, sh_ff[63 - b]};
         if (t >= DIVISOR) begin
            t = t - DIVISOR;
         end
         rem_step = t[RW-1:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      kind_in  = kind_ff;
      plo_in   = plo_ff;
      phi_in   = phi_ff;
      home_in  = home_ff;
      sh_in    = sh_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         lphm_pkg::H_IDLE: begin
            if (start) begin
               plo_in   = plo_c;
               phi_in   = phi_c;
               kind_in  = key_kind;
               state_in = lphm_pkg::H_ADD;
            end
         end
         lphm_pkg::H_ADD: begin
            home_in  = sum_c;
            sh_in    = sum_c;
            rem_in   = '0;
            cnt_in   = '0;
            state_in = POW2 ? lphm_pkg::H_DONE : lphm_pkg::H_MOD;
         end
         lphm_pkg::H_MOD: begin
            rem_in = rem_step;
            sh_in  = {sh_ff[59:0], 4'd0};
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd15) begin
               state_in = lphm_pkg::H_DONE;
            end
         end
         lphm_pkg::H_DONE: begin
            state_in = lphm_pkg::H_IDLE;
         end
         default: begin
            state_in = lphm_pkg::H_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lphm_pkg::H_IDLE;
      end else begin
         state_ff <= state_in;
      end
      kind_ff <= kind_in;
      plo_ff  <= plo_in;
      phi_ff  <= phi_in;
      home_ff <= home_in;
      sh_ff   <= sh_in;
      rem_ff  <= rem_in;
      cnt_ff  <= cnt_in;
   end

   assign done = (state_ff == lphm_pkg::H_DONE);
   assign home = home_ff;
   assign slot = POW2 ? home_ff[SW-1:0] : rem_ff[SW-1:0];

endmodule

`default_nettype wire

@@ sv/linear_probe_hash_map.sv @@
// Top level of the linear probing hash map: control sequencer around one table RAM.
// Depends on lphm_pkg, lphm_channels, lphm_ram and lphm_hash.
//
//   channel  direction  handshake        payload
//   req_ch   in         valid/ready      action, key, value
//   rsp_ch   out        valid/ready      status, found, found_value, entry_count
//   csr      in         csr_wr_en        csr_wr_data (key_kind)
//
// Sequence: hashing (the remainder loop runs only for a depth that is not a power
// of two), then per probe a RAM read and a check/write; the response is then
// registered and the controller returns to idle for the next request.
// Delete adds, per moved entry, a rehash plus its probes.
// Clear sweeps the RAM, one entry per cycle, then returns a response.
// Reset: a sweep over all TABLE_DEPTH slots clears the used bits; no request taken meanwhile.
// Stalls: a response waits in the output register while the next request is accepted.
`default_nettype none

module linear_probe_hash_map #(
   parameter int TABLE_DEPTH = lphm_pkg::DEPTH_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   lphm_req_if.sink         req_ch,
   lphm_rsp_if.source       rsp_ch,
   input  wire logic        csr_wr_en,
   input  wire logic        csr_wr_data
);

   localparam int SW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int EW = $bits(lphm_pkg::entry_type);
   localparam logic [SW-1:0] LAST_SLOT = SW'(TABLE_DEPTH - 1);
   localparam logic [CW-1:0] PROBE_MAX = CW'(TABLE_DEPTH);

   lphm_pkg::ctrl_state_type state_ff, state_in;
   lphm_pkg::phase_type      phase_ff, phase_in;

   logic        kind_ff, boot_ff, boot_in, hgo_ff, hgo_in;
   logic [1:0]  act_ff, act_in;
   logic [63:0] key_ff, key_in, mk_ff, mk_in;
   logic [31:0] val_ff, val_in, mv_ff, mv_in;
   // active probe cursor: 64-bit running sum, slot, probe number
   logic [63:0] sum_ff, sum_in, sv_sum_ff, sv_sum_in;
   logic [SW-1:0] slot_ff, slot_in, sv_slot_ff, sv_slot_in, sweep_ff, sweep_in;
   logic [CW-1:0] idx_ff, idx_in, sv_idx_ff, sv_idx_in, occ_ff, occ_in;
   logic [1:0]  stat_ff, stat_in;
   logic        found_ff, found_in;
   logic [31:0] fval_ff, fval_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;
   logic        rsp_found_ff, rsp_found_in;
   logic [31:0] rsp_fval_ff, rsp_fval_in;
   logic [lphm_pkg::COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic        ram_we, ram_re;
   logic [SW-1:0] ram_waddr;
   lphm_pkg::entry_type ram_wentry, rd_entry;
   logic [EW-1:0] ram_rdata;

   logic        hash_done;
   logic [63:0] hash_home;
   logic [SW-1:0] hash_slot;

   logic [63:0] adv_sum;
   logic [SW-1:0] adv_slot;
   logic [CW-1:0] adv_idx;
   logic        hit;

   assign rd_entry = lphm_pkg::entry_type'(ram_rdata);

   lphm_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wentry),
      .rd_en   (ram_re),
      .rd_addr (slot_ff),
      .rd_data (ram_rdata)
   );

   lphm_hash #(.TABLE_DEPTH(TABLE_DEPTH)) u_hash (
      .clock    (clock),
      .reset    (reset),
      .start    (hgo_ff),
      .key      ((phase_ff == lphm_pkg::PH_REINS) ? mk_ff : key_ff),
      .key_kind (kind_ff),
      .done     (hash_done),
      .home     (hash_home),
      .slot     (hash_slot)
   );

   // next probe position; a wrap of the 64-bit sum lands on slot 0
   assign adv_sum  = sum_ff + 64'd1;
   assign adv_slot = (adv_sum == 64'd0 || slot_ff == LAST_SLOT) ? '0 : slot_ff + SW'(1);
   assign adv_idx  = idx_ff + CW'(1);
   assign hit      = lphm_pkg::keys_match(kind_ff, rd_entry.key,
                        (phase_ff == lphm_pkg::PH_REINS) ? mk_ff : key_ff);

   assign req_ch.ready = (state_ff == lphm_pkg::ST_IDLE);

   always_comb begin
      state_in   = state_ff;
      phase_in   = phase_ff;
      boot_in    = boot_ff;
      hgo_in     = 1'b0;
      act_in     = act_ff;
      key_in     = key_ff;
      val_in     = val_ff;
      mk_in      = mk_ff;
      mv_in      = mv_ff;
      sum_in     = sum_ff;
      slot_in    = slot_ff;
      idx_in     = idx_ff;
      sv_sum_in  = sv_sum_ff;
      sv_slot_in = sv_slot_ff;
      sv_idx_in  = sv_idx_ff;
      sweep_in   = sweep_ff;
      occ_in     = occ_ff;
      stat_in    = stat_ff;
      found_in   = found_ff;
      fval_in    = fval_ff;
      ram_we     = 1'b0;
      ram_re     = 1'b0;
      ram_waddr  = slot_ff;
      ram_wentry = rd_entry;

      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_fval_in   = rsp_fval_ff;
      rsp_count_in  = rsp_count_ff;

      case (state_ff)
         lphm_pkg::ST_SWEEP: begin
            ram_we     = 1'b1;
            ram_waddr  = sweep_ff;
            ram_wentry = '0;
            sweep_in   = sweep_ff + SW'(1);
            if (sweep_ff == LAST_SLOT) begin
               sweep_in = '0;
               boot_in  = 1'b0;
               state_in = boot_ff ? lphm_pkg::ST_IDLE : lphm_pkg::ST_DONE;
            end
         end
         lphm_pkg::ST_IDLE: begin
            if (req_ch.valid) begin
               act_in   = req_ch.action;
               key_in   = req_ch.key;
               val_in   = req_ch.value;
               stat_in  = lphm_pkg::STAT_OK;
               found_in = 1'b0;
               fval_in  = '0;
               phase_in = lphm_pkg::PH_LOOKUP;
               if (req_ch.action == lphm_pkg::ACT_CLEAR) begin
                  occ_in   = '0;
                  sweep_in = '0;
                  state_in = lphm_pkg::ST_SWEEP;
               end else begin
                  hgo_in   = 1'b1;
                  state_in = lphm_pkg::ST_HASH;
               end
            end
         end
         lphm_pkg::ST_HASH: begin
            if (hash_done) begin
               sum_in   = hash_home;
               slot_in  = hash_slot;
               idx_in   = '0;
               state_in = lphm_pkg::ST_READ;
            end
         end
         lphm_pkg::ST_READ: begin
            ram_re   = 1'b1;
            state_in = lphm_pkg::ST_CHECK;
         end
         lphm_pkg::ST_CHECK: begin
            case (phase_ff)
               lphm_pkg::PH_LOOKUP: begin
                  if (!rd_entry.used) begin
                     state_in = lphm_pkg::ST_DONE;
                     if (act_ff == lphm_pkg::ACT_INSERT) begin
                        ram_we     = 1'b1;
                        ram_wentry = '{used: 1'b1, key: key_ff, value: val_ff};
                        occ_in     = occ_ff + CW'(1);
                     end else begin
                        stat_in = lphm_pkg::STAT_MISSING;
                     end
                  end else if (hit) begin
                     state_in = lphm_pkg::ST_DONE;
                     case (act_ff)
                        lphm_pkg::ACT_INSERT: stat_in = lphm_pkg::STAT_EXISTS;
                        lphm_pkg::ACT_SEARCH: begin
                           found_in = 1'b1;
                           fval_in  = rd_entry.value;
                        end
                        default: begin
                           // delete: empty the slot, then walk the rest of the cluster
                           ram_we      = 1'b1;
                           ram_wentry.used = 1'b0;
                           occ_in      = occ_ff - CW'(1);
                           sum_in      = adv_sum;
                           slot_in     = adv_slot;
                           idx_in      = adv_idx;
                           phase_in    = lphm_pkg::PH_SHIFT;
                           if (adv_idx != PROBE_MAX) begin
                              state_in = lphm_pkg::ST_READ;
                           end
                        end
                     endcase
                  end else begin
                     sum_in  = adv_sum;
                     slot_in = adv_slot;
                     idx_in  = adv_idx;
                     if (adv_idx == PROBE_MAX) begin
                        state_in = lphm_pkg::ST_DONE;
                        stat_in  = (act_ff == lphm_pkg::ACT_INSERT) ? lphm_pkg::STAT_FULL
                                                                     : lphm_pkg::STAT_MISSING;
                     end else begin
                        state_in = lphm_pkg::ST_READ;
                     end
                  end
               end
               lphm_pkg::PH_SHIFT: begin
                  if (!rd_entry.used) begin
                     state_in = lphm_pkg::ST_DONE;
                  end else begin
                     // lift the entry out and insert it again from its own home
                     ram_we          = 1'b1;
                     ram_wentry.used = 1'b0;
                     occ_in          = occ_ff - CW'(1);
                     mk_in           = rd_entry.key;
                     mv_in           = rd_entry.value;
                     sv_sum_in       = adv_sum;
                     sv_slot_in      = adv_slot;
                     sv_idx_in       = adv_idx;
                     phase_in        = lphm_pkg::PH_REINS;
                     hgo_in          = 1'b1;
                     state_in        = lphm_pkg::ST_HASH;
                  end
               end
               default: begin
                  // reinsertion: place on empty, drop on a matching key or a full sweep
                  if (!rd_entry.used || hit || adv_idx == PROBE_MAX) begin
                     if (!rd_entry.used) begin
                        ram_we     = 1'b1;
                        ram_wentry = '{used: 1'b1, key: mk_ff, value: mv_ff};
                        occ_in     = occ_ff + CW'(1);
                     end
                     sum_in   = sv_sum_ff;
                     slot_in  = sv_slot_ff;
                     idx_in   = sv_idx_ff;
                     phase_in = lphm_pkg::PH_SHIFT;
                     state_in = (sv_idx_ff == PROBE_MAX) ? lphm_pkg::ST_DONE
                                                         : lphm_pkg::ST_READ;
                  end else begin
                     sum_in   = adv_sum;
                     slot_in  = adv_slot;
                     idx_in   = adv_idx;
                     state_in = lphm_pkg::ST_READ;
                  end
               end
            endcase
         end
         lphm_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = stat_ff;
               rsp_found_in  = found_ff;
               rsp_fval_in   = fval_ff;
               rsp_count_in  = lphm_pkg::COUNT_W'(occ_ff);
               state_in      = lphm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lphm_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lphm_pkg::ST_SWEEP;
         phase_ff     <= lphm_pkg::PH_LOOKUP;
         boot_ff      <= 1'b1;
         hgo_ff       <= 1'b0;
         sweep_ff     <= '0;
         occ_ff       <= '0;
         kind_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         boot_ff      <= boot_in;
         hgo_ff       <= hgo_in;
         sweep_ff     <= sweep_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            kind_ff <= csr_wr_data;
         end
      end
      act_ff        <= act_in;
      key_ff        <= key_in;
      val_ff        <= val_in;
      mk_ff         <= mk_in;
      mv_ff         <= mv_in;
      sum_ff        <= sum_in;
      slot_ff       <= slot_in;
      idx_ff        <= idx_in;
      sv_sum_ff     <= sv_sum_in;
      sv_slot_ff    <= sv_slot_in;
      sv_idx_ff     <= sv_idx_in;
      stat_ff       <= stat_in;
      found_ff      <= found_in;
      fval_ff       <= fval_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_fval_ff   <= rsp_fval_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = rsp_status_ff;
   assign rsp_ch.found       = rsp_found_ff;
   assign rsp_ch.found_value = rsp_fval_ff;
   assign rsp_ch.entry_count = rsp_count_ff;

   // occupancy can never pass the capacity
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= PROBE_MAX)
      else $error("occupancy above table depth");

   // a search hit always reports success
   a_hit_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.found |-> rsp_ch.status == lphm_pkg::STAT_OK)
      else $error("hit with non-success status");

   // every RAM read is checked in the following cycle
   a_read_check: assert property (@(posedge clock) disable iff (reset)
      ram_re |=> state_ff == lphm_pkg::ST_CHECK)
      else $error("read not followed by check");

   // sweeping never overlaps a probe read
   a_sweep_quiet: assert property (@(posedge clock) disable iff (reset)
      state_ff == lphm_pkg::ST_SWEEP |-> !ram_re)
      else $error("read during sweep");

endmodule

`default_nettype wire
